[sv/cprs_pkg.sv]
`timescale 1ns / 1ps

package cprs_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PACKETS_PER_JUMBO     = 2'd0,
        CFG_COALESCE_THRESHOLD_US = 2'd1,
        CFG_INTERARRIVALS         = 2'd2,
        CFG_EXPECTED_REQUEST      = 2'd3
    } cfg_idx_t;

    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = 2;
    localparam int QUEUE_CNT_W  = 3;

    localparam logic [6:0]  PPJ_RESET       = 7'd1;
    localparam logic [23:0] THRESHOLD_RESET = 24'd30;
    localparam logic [15:0] INTERARR_RESET  = 16'd15;
    localparam logic [31:0] EXP_REQ_RESET   = 32'd0;
    localparam logic [31:0] ALL_ONES_32     = '1;

    typedef struct packed {
        logic [6:0]  packets_per_jumbo;
        logic [23:0] coalesce_threshold_us;
        logic [15:0] interarrivals;
        logic [31:0] expected_request;
    } cfg_t;

    typedef struct packed {
        logic [31:0] packet_num;
        logic [31:0] chirp_seq;
        logic [47:0] send_time_us;
        logic [47:0] recv_time_us;
        logic [31:0] request_id;
    } item_t;

    typedef struct packed {
        logic [31:0] rec_chirp;
        logic [31:0] rec_packet;
        logic [47:0] rec_send_us;
        logic [47:0] rec_recv_us;
        logic [31:0] rec_request;
        logic        good_flag;
        logic        last_of_run;
    } rec_t;

    // Records pushed into the output queue in the same cycle
    typedef struct packed {
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

endpackage

[sv/cprs_pkt_if.sv]
`timescale 1ns / 1ps

interface cprs_pkt_if;
    logic        valid;
    logic        ready;
    logic [31:0] packet_num;
    logic [31:0] chirp_seq;
    logic [47:0] send_time_us;
    logic [47:0] recv_time_us;
    logic [31:0] request_id;

    modport source (
        output valid, packet_num, chirp_seq, send_time_us, recv_time_us, request_id,
        input  ready
    );

    modport sink (
        input  valid, packet_num, chirp_seq, send_time_us, recv_time_us, request_id,
        output ready
    );
endinterface

[sv/cprs_rec_if.sv]
`timescale 1ns / 1ps

interface cprs_rec_if;
    logic        valid;
    logic        ready;
    logic [31:0] rec_chirp;
    logic [31:0] rec_packet;
    logic [47:0] rec_send_us;
    logic [47:0] rec_recv_us;
    logic [31:0] rec_request;
    logic        good_flag;
    logic        last_of_run;

    modport source (
        output valid, rec_chirp, rec_packet, rec_send_us, rec_recv_us, rec_request,
               good_flag, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, rec_chirp, rec_packet, rec_send_us, rec_recv_us, rec_request,
               good_flag, last_of_run,
        output ready
    );
endinterface

[sv/cprs_decide.sv]
`timescale 1ns / 1ps

module cprs_decide
    import cprs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  in_ready,
    input  logic  room,
    output push_t push
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    item_t       s1_item_reg;
    logic        fire;

    logic [47:0] prev_recv_reg,  prev_recv_next;
    logic [47:0] prev_send_reg,  prev_send_next;
    logic [31:0] prev_packet_reg, prev_packet_next;
    logic [31:0] prev_chirp_reg, prev_chirp_next;
    logic [47:0] good_recv_reg,  good_recv_next;
    logic [47:0] good_send_reg,  good_send_next;
    logic [31:0] good_packet_reg, good_packet_next;
    logic [31:0] good_chirp_reg, good_chirp_next;

    logic        end_session;
    logic        req_match;
    logic        single;
    logic [47:0] gap;
    logic        gap_hit;
    logic [47:0] g_recv;
    logic [47:0] g_send;
    logic [31:0] g_packet;
    logic [31:0] g_chirp;
    logic [31:0] before_num;
    logic        first_en;
    logic        second_en;
    logic [16:0] last_first;
    logic [31:0] last_first_32;
    rec_t        first_rec;
    rec_t        second_rec;

    assign fire     = s1_valid_reg && room;
    assign in_ready = !s1_valid_reg || room;

    always_comb
    begin
        if (in_valid && in_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_item;
        end
    end

    // Decision
    assign end_session = (s1_item_reg.packet_num == 32'd0);
    assign req_match   = (s1_item_reg.request_id == cfg.expected_request);
    assign single      = (cfg.packets_per_jumbo[6:1] == 6'd0);

    assign gap     = s1_item_reg.recv_time_us - prev_recv_reg;
    assign gap_hit = (s1_item_reg.recv_time_us > prev_recv_reg)
                   && (gap > {24'd0, cfg.coalesce_threshold_us});

    assign g_recv   = gap_hit ? prev_recv_reg   : good_recv_reg;
    assign g_send   = gap_hit ? prev_send_reg   : good_send_reg;
    assign g_packet = gap_hit ? prev_packet_reg : good_packet_reg;
    assign g_chirp  = gap_hit ? prev_chirp_reg  : good_chirp_reg;

    assign before_num = s1_item_reg.packet_num - 32'd1;
    assign first_en   = (s1_item_reg.packet_num > prev_packet_reg)
                      && (prev_packet_reg != 32'd0);

    assign last_first    = {1'b0, cfg.interarrivals} + 17'd1;
    assign last_first_32 = {15'd0, last_first};
    assign second_en     = (s1_item_reg.packet_num == last_first_32)
                         && (prev_packet_reg < last_first_32);

    always_comb
    begin
        // Prefer the last good packet unless only the previous one directly precedes
        if (g_packet != before_num && prev_packet_reg == before_num)
        begin
            first_rec.rec_chirp   = prev_chirp_reg;
            first_rec.rec_packet  = prev_packet_reg;
            first_rec.rec_send_us = prev_send_reg;
            first_rec.rec_recv_us = prev_recv_reg;
            first_rec.good_flag   = 1'b0;
        end
        else
        begin
            first_rec.rec_chirp   = g_chirp;
            first_rec.rec_packet  = g_packet;
            first_rec.rec_send_us = g_send;
            first_rec.rec_recv_us = g_recv;
            first_rec.good_flag   = 1'b1;
        end
        first_rec.rec_request = s1_item_reg.request_id;
        first_rec.last_of_run = !second_en;

        second_rec.rec_chirp   = s1_item_reg.chirp_seq;
        second_rec.rec_packet  = s1_item_reg.packet_num;
        second_rec.rec_send_us = s1_item_reg.send_time_us;
        second_rec.rec_recv_us = s1_item_reg.recv_time_us;
        second_rec.rec_request = s1_item_reg.request_id;
        second_rec.good_flag   = 1'b1;
        second_rec.last_of_run = 1'b1;
    end

    always_comb
    begin
        push.count = 2'd0;
        push.rec0  = second_rec;
        push.rec1  = second_rec;
        if (fire && !end_session && req_match)
        begin
            if (single)
            begin
                push.count = 2'd1;
            end
            else if (first_en)
            begin
                push.count = second_en ? 2'd2 : 2'd1;
                push.rec0  = first_rec;
            end
            else if (second_en)
            begin
                push.count = 2'd1;
            end
        end
    end

    // State update
    always_comb
    begin
        prev_recv_next   = prev_recv_reg;
        prev_send_next   = prev_send_reg;
        prev_packet_next = prev_packet_reg;
        prev_chirp_next  = prev_chirp_reg;
        good_recv_next   = good_recv_reg;
        good_send_next   = good_send_reg;
        good_packet_next = good_packet_reg;
        good_chirp_next  = good_chirp_reg;
        if (fire)
        begin
            if (end_session)
            begin
                prev_recv_next   = '0;
                prev_send_next   = '0;
                prev_packet_next = '0;
                prev_chirp_next  = '0;
                good_recv_next   = '0;
                good_send_next   = '0;
                good_packet_next = ALL_ONES_32;
                good_chirp_next  = ALL_ONES_32;
            end
            else if (req_match && !single)
            begin
                prev_recv_next   = s1_item_reg.recv_time_us;
                prev_send_next   = s1_item_reg.send_time_us;
                prev_packet_next = s1_item_reg.packet_num;
                prev_chirp_next  = s1_item_reg.chirp_seq;
                good_recv_next   = g_recv;
                good_send_next   = g_send;
                good_packet_next = g_packet;
                good_chirp_next  = g_chirp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_recv_reg   <= '0;
            prev_send_reg   <= '0;
            prev_packet_reg <= '0;
            prev_chirp_reg  <= '0;
            good_recv_reg   <= '0;
            good_send_reg   <= '0;
            good_packet_reg <= ALL_ONES_32;
            good_chirp_reg  <= ALL_ONES_32;
        end
        else
        begin
            prev_recv_reg   <= prev_recv_next;
            prev_send_reg   <= prev_send_next;
            prev_packet_reg <= prev_packet_next;
            prev_chirp_reg  <= prev_chirp_next;
            good_recv_reg   <= good_recv_next;
            good_send_reg   <= good_send_next;
            good_packet_reg <= good_packet_next;
            good_chirp_reg  <= good_chirp_next;
        end
    end

endmodule

[sv/cprs_out_queue.sv]
`timescale 1ns / 1ps

module cprs_out_queue
    import cprs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output rec_t  out_rec
);

    rec_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg,  count_next;
    logic [QUEUE_PTR_W-1:0] wr_ptr_plus1;
    logic                   pop;

    assign out_valid    = (count_reg != '0);
    assign out_rec      = mem_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    // Room for two records, counted before this cycle's pop
    assign room         = (count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + QUEUE_PTR_W'(1);

    assign wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
    assign count_next  = count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.rec0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.rec1;
        end
    end

endmodule

[sv/chirp_packet_record_selector.sv]
`timescale 1ns / 1ps

// Chirp packet record selector. Takes one received probe packet per item on
// pkt_in and returns zero, one or two packet records on rec_out; the last
// record of each packet carries last_of_run. Packets of a request other than
// expected_request are dropped silently, and packet number zero ends the
// session and returns the tracking state to reset. The decision for an item
// is made on the input register; records then wait in a four-entry output
// queue that hands out one record per cycle while rec_out.ready is high. A
// record passes through the input register and the output queue before it
// is offered. The block accepts one item per clock as long as the receiver
// takes a record every cycle and the queue holds two records or fewer; each
// packet that yields two records adds one record of backlog, and while
// three or more records wait the input register holds its item and takes
// no new one. Write configuration only while the block is idle; writes
// take effect on the next item.
module chirp_packet_record_selector
    import cprs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    cprs_pkt_if.sink               pkt_in,
    cprs_rec_if.source             rec_out
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    item_t in_item;
    push_t push;
    logic  room;
    rec_t  out_rec;

    // Configuration registers: write the selected register, keep the rest
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PACKETS_PER_JUMBO:     cfg_next.packets_per_jumbo     = cfg_data[6:0];
                CFG_COALESCE_THRESHOLD_US: cfg_next.coalesce_threshold_us = cfg_data[23:0];
                CFG_INTERARRIVALS:         cfg_next.interarrivals         = cfg_data[15:0];
                CFG_EXPECTED_REQUEST:      cfg_next.expected_request      = cfg_data[31:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.packets_per_jumbo     <= PPJ_RESET;
            cfg_reg.coalesce_threshold_us <= THRESHOLD_RESET;
            cfg_reg.interarrivals         <= INTERARR_RESET;
            cfg_reg.expected_request      <= EXP_REQ_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Gather the incoming item
    assign in_item.packet_num   = pkt_in.packet_num;
    assign in_item.chirp_seq    = pkt_in.chirp_seq;
    assign in_item.send_time_us = pkt_in.send_time_us;
    assign in_item.recv_time_us = pkt_in.recv_time_us;
    assign in_item.request_id   = pkt_in.request_id;

    // Input register, decision logic and tracking state
    cprs_decide u_decide (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (pkt_in.valid),
        .in_item  (in_item),
        .in_ready (pkt_in.ready),
        .room     (room),
        .push     (push)
    );

    // Output queue: parts the result side from the input side
    cprs_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (rec_out.valid),
        .out_ready (rec_out.ready),
        .out_rec   (out_rec)
    );

    assign rec_out.rec_chirp   = out_rec.rec_chirp;
    assign rec_out.rec_packet  = out_rec.rec_packet;
    assign rec_out.rec_send_us = out_rec.rec_send_us;
    assign rec_out.rec_recv_us = out_rec.rec_recv_us;
    assign rec_out.rec_request = out_rec.rec_request;
    assign rec_out.good_flag   = out_rec.good_flag;
    assign rec_out.last_of_run = out_rec.last_of_run;

endmodule
